/* src/sbsc_pkg.sv */
// Shared types, constants and codes of the stereo bipolar soft compressor.
// Used by every module of the block; depends on nothing.
package sbsc_pkg;

   // Sample format is fixed by the payload structs
   localparam int SAMPLE_BITS           = 24;
   localparam int CONTROL_FRAC_BITS_DEF = 24;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int MUL_W                 = 64;

   // Register reset values
   localparam logic [15:0] INPUT_GAIN_RST        = 16'd8192;
   localparam logic [14:0] OUTPUT_GAIN_RECIP_RST = 15'd16384;
   localparam logic [19:0] SMOOTHING_COEF_RST    = 20'd0;
   localparam logic [15:0] WET_MIX_RST           = 16'd32768;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INPUT_GAIN,
      CSR_OUTPUT_GAIN_RECIP,
      CSR_SMOOTHING_COEF,
      CSR_WET_MIX
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_data_type;

   // Products computed on the shared multiplier, in issue order
   typedef enum logic [3:0] {
      ST_XG,
      ST_SQP,
      ST_TPOS,
      ST_SQN,
      ST_TNEG,
      ST_CALC,
      ST_CTRL,
      ST_TA,
      ST_TB,
      ST_W1,
      ST_W2,
      ST_P1,
      ST_P2
   } step_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_MUL_GO,
      S_MUL_WAIT,
      S_RECIP,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MIX,
      S_ROUND,
      S_OUT
   } fsm_state_type;

   typedef struct packed {
      step_type step;
      logic     ch;
      logic     load_sample;
      logic     prep;
      logic     mul_start;
      logic     div_start;
      logic     load_cmax;
      logic     mix;
      logic     round;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic tgt_zero;
      logic out_free;
   } stat_type;

endpackage

/* src/sbsc_mul.sv */
// Shared multiplier: 64x64 product built from four 64x16 partial products,
// then rounded half up, shifted right and saturated. Depends on sbsc_pkg.
module sbsc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sbsc_pkg::MUL_W-1:0] op_a,
   input  logic [sbsc_pkg::MUL_W-1:0] op_b,
   input  logic [5:0]                 shift,
   input  logic [sbsc_pkg::MUL_W-1:0] cap,
   output logic [sbsc_pkg::MUL_W-1:0] result,
   output logic                       done
);

   localparam int W = sbsc_pkg::MUL_W;

   logic           busy_ff, busy_in;
   logic           fin_ff, fin_in;
   logic           done_ff, done_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic [W-1:0]   a_ff, a_in, b_ff, b_in, cap_ff, cap_in, res_ff, res_in;
   logic [5:0]     s_ff, s_in;
   logic [2*W-1:0] acc_ff, acc_in;

   logic [15:0]    digit;
   logic [W+15:0]  pp;
   logic [2*W-1:0] pp_sh, rnd, sum, shd;
   logic [W-1:0]   low;

   // Partial product of the current 16-bit digit
   always_comb begin
      digit = b_ff[{cnt_ff, 4'b0000} +: 16];
      pp    = (W+16)'(a_ff) * (W+16)'(digit);
      pp_sh = (2*W)'(pp) << {cnt_ff, 4'b0000};
   end

   // Round, shift and saturate
   always_comb begin
      rnd = (s_ff == 6'd0) ? '0 : ((2*W)'(1) << (s_ff - 6'd1));
      sum = acc_ff + rnd;
      shd = sum >> s_ff;
      low = shd[W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      s_in    = s_ff;
      cap_in  = cap_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         a_in    = op_a;
         b_in    = op_b;
         s_in    = shift;
         cap_in  = cap;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         res_in = ((|shd[2*W-1:W]) || (low > cap_ff)) ? cap_ff : low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      s_ff   <= s_in;
      cap_ff <= cap_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

/* src/sbsc_div.sv */
// Restoring divider, one quotient bit a cycle: 2^(26+CONTROL_FRAC_BITS) / target.
// Depends on sbsc_pkg for the default parameter.
module sbsc_div #(
   parameter int CONTROL_FRAC_BITS = sbsc_pkg::CONTROL_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  divisor,
   output logic [CONTROL_FRAC_BITS+26:0] quotient,
   output logic                         done
);

   localparam int QW   = CONTROL_FRAC_BITS + 27;
   localparam int CNTW = $clog2(QW + 1);

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [32:0]     rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [31:0]     t_ff, t_in;
   logic            done_ff, done_in;

   logic        nbit;
   logic [32:0] rem_sh;
   logic        ge;

   // The dividend is a single one at its top bit
   always_comb begin
      nbit   = (cnt_ff == CNTW'(QW));
      rem_sh = {rem_ff[31:0], nbit};
      ge     = (rem_sh >= {1'b0, t_ff});
   end

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      t_in    = t_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNTW'(QW);
         rem_in = '0;
         t_in   = divisor;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? (rem_sh - {1'b0, t_ff}) : rem_sh;
         q_in    = {q_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CNTW'(1);
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      t_ff   <= t_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

/* src/sbsc_ctrl.sv */
// Sequencer of the compressor: walks each channel through the product steps,
// the reciprocal division, the mix and the output load. Depends on sbsc_pkg.
module sbsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sbsc_pkg::stat_type stat,
   output sbsc_pkg::cmd_type  cmd
);

   sbsc_pkg::fsm_state_type state_ff, state_in;
   sbsc_pkg::step_type      step_ff, step_in;
   logic                    ch_ff, ch_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ch_in    = ch_ff;
      case (state_ff)
         sbsc_pkg::S_IDLE: begin
            if (req_valid) begin
               ch_in    = 1'b0;
               state_in = sbsc_pkg::S_PREP;
            end
         end
         sbsc_pkg::S_PREP: begin
            step_in  = sbsc_pkg::ST_XG;
            state_in = sbsc_pkg::S_MUL_GO;
         end
         sbsc_pkg::S_MUL_GO: begin
            state_in = sbsc_pkg::S_MUL_WAIT;
         end
         sbsc_pkg::S_MUL_WAIT: begin
            if (stat.mul_done) begin
               state_in = sbsc_pkg::S_MUL_GO;
               case (step_ff)
                  sbsc_pkg::ST_XG:   step_in = sbsc_pkg::ST_SQP;
                  sbsc_pkg::ST_SQP:  step_in = sbsc_pkg::ST_TPOS;
                  sbsc_pkg::ST_TPOS: step_in = sbsc_pkg::ST_SQN;
                  sbsc_pkg::ST_SQN:  step_in = sbsc_pkg::ST_TNEG;
                  sbsc_pkg::ST_TNEG: state_in = sbsc_pkg::S_RECIP;
                  sbsc_pkg::ST_CALC: step_in = sbsc_pkg::ST_CTRL;
                  sbsc_pkg::ST_CTRL: step_in = sbsc_pkg::ST_TA;
                  sbsc_pkg::ST_TA:   step_in = sbsc_pkg::ST_TB;
                  sbsc_pkg::ST_TB:   step_in = sbsc_pkg::ST_W1;
                  sbsc_pkg::ST_W1:   step_in = sbsc_pkg::ST_W2;
                  sbsc_pkg::ST_W2:   step_in = sbsc_pkg::ST_P1;
                  sbsc_pkg::ST_P1:   step_in = sbsc_pkg::ST_P2;
                  sbsc_pkg::ST_P2:   state_in = sbsc_pkg::S_MIX;
                  default:           state_in = sbsc_pkg::S_IDLE;
               endcase
            end
         end
         sbsc_pkg::S_RECIP: begin
            // A zero target skips the division and uses the control maximum
            if (stat.tgt_zero) begin
               step_in  = sbsc_pkg::ST_CTRL;
               state_in = sbsc_pkg::S_MUL_GO;
            end else begin
               state_in = sbsc_pkg::S_DIV_GO;
            end
         end
         sbsc_pkg::S_DIV_GO: begin
            state_in = sbsc_pkg::S_DIV_WAIT;
         end
         sbsc_pkg::S_DIV_WAIT: begin
            if (stat.div_done) begin
               step_in  = sbsc_pkg::ST_CALC;
               state_in = sbsc_pkg::S_MUL_GO;
            end
         end
         sbsc_pkg::S_MIX: begin
            state_in = sbsc_pkg::S_ROUND;
         end
         sbsc_pkg::S_ROUND: begin
            if (ch_ff) begin
               state_in = sbsc_pkg::S_OUT;
            end else begin
               ch_in    = 1'b1;
               state_in = sbsc_pkg::S_PREP;
            end
         end
         sbsc_pkg::S_OUT: begin
            if (stat.out_free) begin
               state_in = sbsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbsc_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd             = '0;
      cmd.step        = step_ff;
      cmd.ch          = ch_ff;
      req_stall       = (state_ff != sbsc_pkg::S_IDLE);
      case (state_ff)
         sbsc_pkg::S_IDLE:   cmd.load_sample = req_valid;
         sbsc_pkg::S_PREP:   cmd.prep        = 1'b1;
         sbsc_pkg::S_MUL_GO: cmd.mul_start   = 1'b1;
         sbsc_pkg::S_RECIP:  cmd.load_cmax   = stat.tgt_zero;
         sbsc_pkg::S_DIV_GO: cmd.div_start   = 1'b1;
         sbsc_pkg::S_MIX:    cmd.mix         = 1'b1;
         sbsc_pkg::S_ROUND:  cmd.round       = 1'b1;
         sbsc_pkg::S_OUT:    cmd.out_load    = stat.out_free;
         default:            cmd.step        = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbsc_pkg::S_IDLE;
         step_ff  <= sbsc_pkg::ST_XG;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

/* src/sbsc_datapath.sv */
// Datapath of the compressor: registers, envelope and control state, operand
// selection for the shared multiplier and divider, mix and output register.
// Depends on sbsc_pkg, sbsc_mul and sbsc_div.
module sbsc_datapath #(
   parameter int CONTROL_FRAC_BITS = sbsc_pkg::CONTROL_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sbsc_pkg::req_data_type                req_data,
   output sbsc_pkg::rsp_data_type                rsp_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  csr_write,
   input  logic [sbsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [31:0]                           csr_data,
   input  sbsc_pkg::cmd_type                     cmd,
   output sbsc_pkg::stat_type                    stat
);

   localparam int SB   = sbsc_pkg::SAMPLE_BITS;
   localparam int FRAC = SB - 1;
   localparam int CFB  = CONTROL_FRAC_BITS;
   localparam int CW   = CFB + 16;
   localparam int QW   = CFB + 27;
   localparam int W    = sbsc_pkg::MUL_W;

   localparam logic [31:0]   ONE26  = 32'd1 << 26;
   localparam logic [W-1:0]  BIGCAP = W'(1) << 62;
   localparam logic [W-1:0]  TMAX   = W'(32'hFFFF_FFFF);
   localparam logic [W-1:0]  CMAX   = (W'(1) << CW) - W'(1);
   localparam logic [W-1:0]  W1CAP  = (W'(1) << 49) - W'(1);
   localparam logic [W-1:0]  W2CAP  = W'(1) << 47;
   localparam logic [CW-1:0] CONE   = CW'(1) << CFB;

   // Configuration registers
   logic [15:0] in_gain_ff, in_gain_in;
   logic [14:0] og_recip_ff, og_recip_in;
   logic [19:0] coef_ff, coef_in;
   logic [15:0] wet_mix_ff, wet_mix_in;

   // Per-channel state, index 0 left, 1 right
   logic [31:0]   tpos_ff [2];
   logic [31:0]   tpos_in [2];
   logic [31:0]   tneg_ff [2];
   logic [31:0]   tneg_in [2];
   logic [CW-1:0] cpos_ff [2];
   logic [CW-1:0] cpos_in [2];
   logic [CW-1:0] cneg_ff [2];
   logic [CW-1:0] cneg_in [2];

   // Working registers
   sbsc_pkg::req_data_type smp_ff, smp_in;
   logic          neg_ff, neg_in;
   logic [SB-1:0] mx_ff, mx_in;
   logic [31:0]   xgm_ff, xgm_in;
   logic [CW-1:0] goal_ff, goal_in;
   logic [CW-1:0] ta_ff, ta_in;
   logic [CW:0]   total_ff, total_in;
   logic [48:0]   w1_ff, w1_in;
   logic [47:0]   w2_ff, w2_in;
   logic [W-1:0]  p1_ff, p1_in, p2_ff, p2_in, mix_ff, mix_in;
   logic [SB-1:0] outl_ff, outl_in, outr_ff, outr_in;
   sbsc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Shared units
   logic [W-1:0]  mul_a, mul_b, mul_cap, mul_res;
   logic [5:0]    mul_s;
   logic          mul_done, div_done;
   logic [QW-1:0] div_q;

   // Derived values
   logic [SB-1:0] smp_sel;
   logic          xg_pos;
   logic [31:0]   pos, ngt, goal32, tcur_p, tcur_n, tact;
   logic [31:0]   opos, oneg;
   logic [CW-1:0] cact;
   logic          tp_ge, tn_ge, c_ge;
   logic [31:0]   tp_diff, tn_diff;
   logic [CW-1:0] c_diff;
   logic [32:0]   tp_sum, tn_sum;
   logic [CW:0]   c_sum;
   logic [31:0]   tp_new, tn_new;
   logic [CW-1:0] c_new;
   logic [15:0]   wet, dry;
   logic [W-1:0]  omag64, capv;
   logic [SB-1:0] omag, oval;

   // Polarity terms and blend weights
   always_comb begin
      smp_sel = cmd.ch ? smp_ff.right_sample : smp_ff.left_sample;
      xg_pos  = !neg_ff && (xgm_ff != 32'd0);
      if (neg_ff) begin
         pos = (xgm_ff >= ONE26) ? 32'd0 : (ONE26 - xgm_ff);
         ngt = ONE26 + xgm_ff;
      end else begin
         pos = ONE26 + xgm_ff;
         ngt = (xgm_ff >= ONE26) ? 32'd0 : (ONE26 - xgm_ff);
      end
      opos = ((pos >> 1) > ONE26) ? ONE26 : (pos >> 1);
      oneg = ((ngt >> 1) > ONE26) ? ONE26 : (ngt >> 1);
   end

   // Smoothing differences and updated values
   always_comb begin
      goal32  = goal_ff[31:0];
      tcur_p  = tpos_ff[cmd.ch];
      tcur_n  = tneg_ff[cmd.ch];
      tact    = xg_pos ? tcur_p : tcur_n;
      cact    = xg_pos ? cpos_ff[cmd.ch] : cneg_ff[cmd.ch];
      tp_ge   = (goal32 >= tcur_p);
      tn_ge   = (goal32 >= tcur_n);
      c_ge    = (goal_ff >= cact);
      tp_diff = tp_ge ? (goal32 - tcur_p) : (tcur_p - goal32);
      tn_diff = tn_ge ? (goal32 - tcur_n) : (tcur_n - goal32);
      c_diff  = c_ge ? (goal_ff - cact) : (cact - goal_ff);
      tp_sum  = {1'b0, tcur_p} + {1'b0, mul_res[31:0]};
      tn_sum  = {1'b0, tcur_n} + {1'b0, mul_res[31:0]};
      c_sum   = {1'b0, cact} + {1'b0, mul_res[CW-1:0]};
      tp_new  = tp_ge ? (tp_sum[32] ? 32'hFFFF_FFFF : tp_sum[31:0])
                      : (tcur_p - mul_res[31:0]);
      tn_new  = tn_ge ? (tn_sum[32] ? 32'hFFFF_FFFF : tn_sum[31:0])
                      : (tcur_n - mul_res[31:0]);
      c_new   = c_ge ? (c_sum[CW] ? CMAX[CW-1:0] : c_sum[CW-1:0])
                     : (cact - mul_res[CW-1:0]);
      wet     = (wet_mix_ff > 16'd32768) ? 16'd32768 : wet_mix_ff;
      dry     = 16'd32768 - wet;
   end

   // Multiplier operand selection
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_s   = 6'd0;
      mul_cap = ~W'(0);
      case (cmd.step)
         sbsc_pkg::ST_XG: begin
            mul_a = W'(mx_ff);   mul_b = W'(in_gain_ff);
            mul_s = 6'(FRAC - 13); mul_cap = BIGCAP;
         end
         sbsc_pkg::ST_SQP: begin
            mul_a = W'(pos); mul_b = W'(pos); mul_s = 6'd26; mul_cap = TMAX;
         end
         sbsc_pkg::ST_TPOS: begin
            mul_a = W'(tp_diff); mul_b = W'(coef_ff); mul_s = 6'd32; mul_cap = TMAX;
         end
         sbsc_pkg::ST_SQN: begin
            mul_a = W'(ngt); mul_b = W'(ngt); mul_s = 6'd26; mul_cap = TMAX;
         end
         sbsc_pkg::ST_TNEG: begin
            mul_a = W'(tn_diff); mul_b = W'(coef_ff); mul_s = 6'd32; mul_cap = TMAX;
         end
         sbsc_pkg::ST_CALC: begin
            mul_a = W'(div_q); mul_b = W'(div_q); mul_s = 6'(CFB); mul_cap = CMAX;
         end
         sbsc_pkg::ST_CTRL: begin
            mul_a = W'(c_diff); mul_b = W'(coef_ff); mul_s = 6'd32; mul_cap = CMAX;
         end
         sbsc_pkg::ST_TA: begin
            mul_a = W'(cpos_ff[cmd.ch]); mul_b = W'(opos);
            mul_s = 6'd26; mul_cap = CMAX;
         end
         sbsc_pkg::ST_TB: begin
            mul_a = W'(cneg_ff[cmd.ch]); mul_b = W'(oneg);
            mul_s = 6'd26; mul_cap = CMAX;
         end
         sbsc_pkg::ST_W1: begin
            mul_a = W'(xgm_ff); mul_b = W'(total_ff);
            mul_s = 6'(CFB - 6); mul_cap = W1CAP;
         end
         sbsc_pkg::ST_W2: begin
            mul_a = W'(w1_ff); mul_b = W'(og_recip_ff); mul_s = 6'd14; mul_cap = W2CAP;
         end
         sbsc_pkg::ST_P1: begin
            mul_a = W'(w2_ff); mul_b = W'(wet);
         end
         sbsc_pkg::ST_P2: begin
            mul_a = W'(mx_ff) << (32 - FRAC); mul_b = W'(dry);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Output rounding and saturation
   always_comb begin
      omag64 = (mix_ff + (W'(1) << (31 - FRAC))) >> (32 - FRAC);
      capv   = neg_ff ? (W'(1) << FRAC) : ((W'(1) << FRAC) - W'(1));
      omag   = (omag64 > capv) ? capv[SB-1:0] : omag64[SB-1:0];
      oval   = neg_ff ? (~omag + SB'(1)) : omag;
   end

   // Next values
   always_comb begin
      in_gain_in  = in_gain_ff;
      og_recip_in = og_recip_ff;
      coef_in     = coef_ff;
      wet_mix_in  = wet_mix_ff;
      tpos_in     = tpos_ff;
      tneg_in     = tneg_ff;
      cpos_in     = cpos_ff;
      cneg_in     = cneg_ff;
      smp_in      = smp_ff;
      neg_in      = neg_ff;
      mx_in       = mx_ff;
      xgm_in      = xgm_ff;
      goal_in     = goal_ff;
      ta_in       = ta_ff;
      total_in    = total_ff;
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      mix_in      = mix_ff;
      outl_in     = outl_ff;
      outr_in     = outr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // register writes
      if (csr_write) begin
         case (csr_index)
            sbsc_pkg::CSR_INPUT_GAIN:        in_gain_in  = csr_data[15:0];
            sbsc_pkg::CSR_OUTPUT_GAIN_RECIP: og_recip_in = csr_data[14:0];
            sbsc_pkg::CSR_SMOOTHING_COEF:    coef_in     = csr_data[19:0];
            sbsc_pkg::CSR_WET_MIX:           wet_mix_in  = csr_data[15:0];
            default:                         coef_in     = coef_ff;
         endcase
      end

      if (cmd.load_sample) begin
         smp_in = req_data;
      end
      // sign and magnitude; the most negative code maps to 2^(SB-1)
      if (cmd.prep) begin
         neg_in = smp_sel[SB-1];
         mx_in  = smp_sel[SB-1] ? (~smp_sel + SB'(1)) : smp_sel;
      end
      if (cmd.load_cmax) begin
         goal_in = CMAX[CW-1:0];
      end

      // multiplier write-back
      if (mul_done) begin
         case (cmd.step)
            sbsc_pkg::ST_XG:   xgm_in = mul_res[31:0];
            sbsc_pkg::ST_SQP:  goal_in = CW'(mul_res[31:0]);
            sbsc_pkg::ST_TPOS: tpos_in[cmd.ch] = tp_new;
            sbsc_pkg::ST_SQN:  goal_in = CW'(mul_res[31:0]);
            sbsc_pkg::ST_TNEG: tneg_in[cmd.ch] = tn_new;
            sbsc_pkg::ST_CALC: goal_in = mul_res[CW-1:0];
            sbsc_pkg::ST_CTRL: begin
               if (xg_pos) begin
                  cpos_in[cmd.ch] = c_new;
               end else begin
                  cneg_in[cmd.ch] = c_new;
               end
            end
            sbsc_pkg::ST_TA:   ta_in = mul_res[CW-1:0];
            sbsc_pkg::ST_TB:   total_in = {1'b0, ta_ff} + {1'b0, mul_res[CW-1:0]};
            sbsc_pkg::ST_W1:   w1_in = mul_res[48:0];
            sbsc_pkg::ST_W2:   w2_in = mul_res[47:0];
            sbsc_pkg::ST_P1:   p1_in = mul_res;
            sbsc_pkg::ST_P2:   p2_in = mul_res;
            default:           p2_in = p2_ff;
         endcase
      end

      if (cmd.mix) begin
         mix_in = (p1_ff + p2_ff + W'(16384)) >> 15;
      end
      if (cmd.round) begin
         if (cmd.ch) begin
            outr_in = oval;
         end else begin
            outl_in = oval;
         end
      end
      if (cmd.out_load) begin
         rsp_data_in.left_out  = outl_ff;
         rsp_data_in.right_out = outr_ff;
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_gain_ff   <= sbsc_pkg::INPUT_GAIN_RST;
         og_recip_ff  <= sbsc_pkg::OUTPUT_GAIN_RECIP_RST;
         coef_ff      <= sbsc_pkg::SMOOTHING_COEF_RST;
         wet_mix_ff   <= sbsc_pkg::WET_MIX_RST;
         tpos_ff      <= '{ONE26, ONE26};
         tneg_ff      <= '{ONE26, ONE26};
         cpos_ff      <= '{CONE, CONE};
         cneg_ff      <= '{CONE, CONE};
         rsp_valid_ff <= 1'b0;
      end else begin
         in_gain_ff   <= in_gain_in;
         og_recip_ff  <= og_recip_in;
         coef_ff      <= coef_in;
         wet_mix_ff   <= wet_mix_in;
         tpos_ff      <= tpos_in;
         tneg_ff      <= tneg_in;
         cpos_ff      <= cpos_in;
         cneg_ff      <= cneg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff      <= smp_in;
      neg_ff      <= neg_in;
      mx_ff       <= mx_in;
      xgm_ff      <= xgm_in;
      goal_ff     <= goal_in;
      ta_ff       <= ta_in;
      total_ff    <= total_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      mix_ff      <= mix_in;
      outl_ff     <= outl_in;
      outr_ff     <= outr_in;
      rsp_data_ff <= rsp_data_in;
   end

   sbsc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .shift  (mul_s),
      .cap    (mul_cap),
      .result (mul_res),
      .done   (mul_done)
   );

   sbsc_div #(
      .CONTROL_FRAC_BITS (CONTROL_FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (tact),
      .quotient (div_q),
      .done     (div_done)
   );

   // Status back to the sequencer
   always_comb begin
      stat.mul_done = mul_done;
      stat.div_done = div_done;
      stat.tgt_zero = (tact == 32'd0);
      stat.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_data  = rsp_data_ff;
   assign rsp_valid = rsp_valid_ff;

   // The two shared units never finish in the same cycle
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   // The output register is loaded only when its transaction is gone
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // A positive-polarity control update leaves the negative controls alone
   a_polarity: assert property (@(posedge clock) disable iff (reset)
      (mul_done && cmd.step == sbsc_pkg::ST_CTRL && xg_pos)
      |=> ($stable(cneg_ff[0]) && $stable(cneg_ff[1])))
      else $error("inactive polarity control changed");

endmodule

/* src/stereo_bipolar_soft_compressor.sv */
// Stereo bipolar soft compressor: one stereo frame in, one compressed and
// wet/dry mixed frame out. The time a frame takes is set by the shared 64x16
// multiplier (thirteen products per channel, twelve for a channel whose active
// target is zero, as the reciprocal division and its product are then skipped)
// and by the divider that forms the reciprocal one quotient bit a cycle. The next
// frame is taken while the previous result still waits in the output register.
// Registers are to be written through the csr_ port only while no frame is in
// flight; the block itself does not enforce this.
// Depends on sbsc_pkg, sbsc_ctrl and sbsc_datapath.
module stereo_bipolar_soft_compressor #(
   parameter int CONTROL_FRAC_BITS = sbsc_pkg::CONTROL_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sbsc_pkg::req_data_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sbsc_pkg::rsp_data_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_data
);

   sbsc_pkg::cmd_type  cmd;
   sbsc_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   sbsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbsc_datapath #(
      .CONTROL_FRAC_BITS (CONTROL_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
